// ===== rtl/core/stop_and_wait_arq_backoff_fsm_core_assert.svh =====
// Assertion macros shared by the core RTL.
// Both macros sample on the rising clock edge and stay quiet while reset is low.
`ifndef STOP_AND_WAIT_ARQ_BACKOFF_FSM_CORE_ASSERT_SVH
`define STOP_AND_WAIT_ARQ_BACKOFF_FSM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWARQ_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define SWARQ_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define SWARQ_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons)
`define SWARQ_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

// ===== rtl/core/swarq_pkg.sv =====
`timescale 1ns / 1ps

package swarq_pkg;

    localparam int DRAW_W   = 16;   // random draw, dividend of the slot remainder
    localparam int DIV_W    = 11;   // window 2^e+1, e <= 10
    localparam int SLOT_W   = 16;   // slot length
    localparam int TIMER_W  = 26;   // armed duration
    localparam int CFG_W    = 16;   // widest register
    localparam int CFG_AW   = 3;

    localparam int DIV_STEPS = DRAW_W;  // one quotient bit per cycle
    localparam int MUL_STEPS = DIV_W;   // one multiplier bit per cycle

    localparam logic [3:0] EXP_LIMIT = 4'd10;
    localparam logic [4:0] ATT_SAT   = 5'd31;
    localparam logic [7:0] BO_SAT    = 8'd255;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_WAIT_ACK  = 2'd1,
        MODE_WAIT_CHAN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        OP_TX_REQ     = 2'd0,
        OP_BACKOFF_TO = 2'd1,
        OP_ACK_TO     = 2'd2,
        OP_RX_FRAME   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_TX        = 3'd1,
        ACT_BACKOFF   = 3'd2,
        ACT_DELIVERED = 3'd3,
        ACT_FAILED    = 3'd4,
        ACT_LISTEN    = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        CFG_SELF_ADDR   = 3'd0,
        CFG_MAX_RETRIES = 3'd1,
        CFG_MAX_BO_EXP  = 3'd2,
        CFG_SLOT_MS     = 3'd3,
        CFG_BASE_POWER  = 3'd4,
        CFG_POWER_STEP  = 3'd5,
        CFG_ACK_WAIT    = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_ACCEPT = 2'd0,
        SEQ_MOD    = 2'd1,
        SEQ_MUL    = 2'd2,
        SEQ_OUT    = 2'd3
    } seq_t;

    // input word, first field in the highest bits
    typedef struct packed {
        logic        rx_is_ack;
        logic [15:0] rx_id;
        logic [7:0]  rx_dest;
        logic [7:0]  rx_source;
        logic [15:0] random_draw;
        logic        send_ok;
        logic        channel_idle;
        logic [15:0] next_id;
        logic [7:0]  next_dest;
        logic        queue_has_frame;
    } in_word_t;

    localparam int IN_W      = $bits(in_word_t);
    localparam int IN_BYTES  = (IN_W + 7) / 8;

    // result word, first field in the highest bits
    typedef struct packed {
        logic        request_next;
        logic [15:0] report_id;
        logic        stop_timer;
        logic [25:0] timer_ms;
        logic [7:0]  tx_power;
        logic [4:0]  retry_field;
        logic        pop_queue;
    } out_word_t;

    localparam int OUT_W     = $bits(out_word_t);
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

endpackage

// ===== rtl/core/stop_and_wait_arq_backoff_fsm_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tuser: opcode; tdata: event fields
// m_*       out  m_tvalid/m_tready   tuser: action; tdata: result fields
// cfg_*     in   cfg_we              cfg_addr register index, cfg_wdata value
//
// Events that arm no backoff go from accept straight to the output load.
// A backoff event first runs the bit-serial remainder of the random draw,
// then the shift-add slot multiply, then the output load.
// rst_n is asynchronous; it clears mode, counters and pending frame, and loads
// the register defaults.
// A result held on a stalled m_tready does not block the next accept; a second
// result waits in its stage until the output register frees up.
`include "stop_and_wait_arq_backoff_fsm_core_assert.svh"

module stop_and_wait_arq_backoff_fsm_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [1:0]                            s_tuser,   // opcode
    // queue_has_frame, next_dest, next_id, channel_idle, send_ok,
    // random_draw, rx_source, rx_dest, rx_id, rx_is_ack
    input  logic [swarq_pkg::IN_BYTES*8-1:0]      s_tdata,

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [2:0]                            m_tuser,   // action
    // pop_queue, retry_field, tx_power, timer_ms, stop_timer,
    // report_id, request_next
    output logic [swarq_pkg::OUT_BYTES*8-1:0]     m_tdata,

    input  logic                                  cfg_we,
    input  logic [swarq_pkg::CFG_AW-1:0]          cfg_addr,
    input  logic [swarq_pkg::CFG_W-1:0]           cfg_wdata
);

    // configuration
    logic [7:0]  self_addr_reg;
    logic [3:0]  max_retries_reg;
    logic [3:0]  max_bo_exp_reg;
    logic [15:0] slot_ms_reg;
    logic [4:0]  base_power_reg;
    logic [2:0]  power_step_reg;
    logic [15:0] ack_wait_reg;

    // protocol state
    swarq_pkg::mode_t mode_reg, mode_next;
    logic [4:0]       att_reg, att_next;
    logic [7:0]       bo_reg, bo_next;
    logic [7:0]       pdest_reg, pdest_next;
    logic [15:0]      pid_reg, pid_next;

    swarq_pkg::seq_t  seq_reg, seq_next;

    swarq_pkg::in_word_t  in_w;
    swarq_pkg::op_t       op;
    swarq_pkg::out_word_t res;
    swarq_pkg::act_t      act;
    logic                 need_bo;
    logic [3:0]           bo_exp;

    swarq_pkg::out_word_t res_reg;
    swarq_pkg::act_t      act_reg;
    swarq_pkg::out_word_t m_word_reg;
    swarq_pkg::act_t      m_act_reg;
    logic                 m_tvalid_reg;

    logic                          s_accept;
    logic                          out_free;
    logic                          out_load;
    logic                          mod_start;
    logic                          mod_done;
    logic [swarq_pkg::DIV_W-1:0]   mod_rem;
    logic                          mul_start;
    logic                          mul_done;
    logic [swarq_pkg::TIMER_W-1:0] mul_prod;

    assign in_w     = swarq_pkg::in_word_t'(s_tdata[swarq_pkg::IN_W-1:0]);
    assign op       = swarq_pkg::op_t'(s_tuser);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_addr_reg   <= 8'd1;
            max_retries_reg <= 4'd3;
            max_bo_exp_reg  <= 4'd5;
            slot_ms_reg     <= 16'd100;
            base_power_reg  <= 5'd2;
            power_step_reg  <= 3'd1;
            ack_wait_reg    <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (swarq_pkg::cfg_idx_t'(cfg_addr))
                swarq_pkg::CFG_SELF_ADDR:   self_addr_reg   <= cfg_wdata[7:0];
                swarq_pkg::CFG_MAX_RETRIES: max_retries_reg <= cfg_wdata[3:0];
                swarq_pkg::CFG_MAX_BO_EXP:  max_bo_exp_reg  <= cfg_wdata[3:0];
                swarq_pkg::CFG_SLOT_MS:     slot_ms_reg     <= cfg_wdata;
                swarq_pkg::CFG_BASE_POWER:  base_power_reg  <= cfg_wdata[4:0];
                swarq_pkg::CFG_POWER_STEP:  power_step_reg  <= cfg_wdata[2:0];
                swarq_pkg::CFG_ACK_WAIT:    ack_wait_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- event decision ----------------
    always_comb
    begin
        logic [4:0]         att_eff;
        logic               go_send;
        logic               go_bo;
        logic               go_fin;
        swarq_pkg::act_t    fin_act;

        res        = '0;
        act        = swarq_pkg::ACT_NONE;
        need_bo    = 1'b0;
        bo_exp     = '0;
        mode_next  = mode_reg;
        att_next   = att_reg;
        bo_next    = bo_reg;
        pdest_next = pdest_reg;
        pid_next   = pid_reg;
        att_eff    = att_reg;
        go_send    = 1'b0;
        go_bo      = 1'b0;
        go_fin     = 1'b0;
        fin_act    = swarq_pkg::ACT_NONE;

        case (mode_reg)
            swarq_pkg::MODE_IDLE:
            begin
                if (op == swarq_pkg::OP_TX_REQ)
                begin
                    if (in_w.queue_has_frame)
                    begin
                        res.pop_queue = 1'b1;
                        pdest_next    = in_w.next_dest;
                        pid_next      = in_w.next_id;
                        att_eff       = '0;
                        att_next      = '0;
                        go_send       = in_w.channel_idle;
                        go_bo         = !in_w.channel_idle;
                    end
                    else
                    begin
                        act = swarq_pkg::ACT_LISTEN;
                    end
                end
            end
            swarq_pkg::MODE_WAIT_CHAN:
            begin
                if (op == swarq_pkg::OP_BACKOFF_TO)
                begin
                    go_send = in_w.channel_idle;
                    go_bo   = !in_w.channel_idle;
                end
            end
            swarq_pkg::MODE_WAIT_ACK:
            begin
                if (op == swarq_pkg::OP_RX_FRAME)
                begin
                    if (in_w.rx_is_ack && (in_w.rx_dest == self_addr_reg) &&
                        (in_w.rx_source == pdest_reg) && (in_w.rx_id == pid_reg))
                    begin
                        res.stop_timer = 1'b1;
                        go_fin         = 1'b1;
                        fin_act        = swarq_pkg::ACT_DELIVERED;
                    end
                end
                else if (op == swarq_pkg::OP_ACK_TO)
                begin
                    if (att_reg > {1'b0, max_retries_reg})
                    begin
                        go_fin  = 1'b1;
                        fin_act = swarq_pkg::ACT_FAILED;
                    end
                    else
                    begin
                        go_send = in_w.channel_idle;
                        go_bo   = !in_w.channel_idle;
                    end
                end
            end
            default:
            begin
                mode_next = swarq_pkg::MODE_IDLE;
            end
        endcase

        // radio refused: back off in place of the send
        if (go_send && !in_w.send_ok)
        begin
            go_send = 1'b0;
            go_bo   = 1'b1;
        end

        if (go_send)
        begin
            bo_next         = '0;
            att_next        = (att_eff != swarq_pkg::ATT_SAT) ? att_eff + 5'd1 : att_eff;
            mode_next       = swarq_pkg::MODE_WAIT_ACK;
            act             = swarq_pkg::ACT_TX;
            res.retry_field = att_eff;
            res.tx_power    = 8'(base_power_reg) + 8'(att_eff) * 8'(power_step_reg);
            res.timer_ms    = swarq_pkg::TIMER_W'(ack_wait_reg);
        end

        if (go_bo)
        begin
            if (bo_reg > {4'd0, max_bo_exp_reg})
            begin
                bo_exp = max_bo_exp_reg;
            end
            else
            begin
                bo_exp = bo_reg[3:0];
            end
            if (bo_exp > swarq_pkg::EXP_LIMIT)
            begin
                bo_exp = swarq_pkg::EXP_LIMIT;
            end
            bo_next   = (bo_reg != swarq_pkg::BO_SAT) ? bo_reg + 8'd1 : bo_reg;
            mode_next = swarq_pkg::MODE_WAIT_CHAN;
            act       = swarq_pkg::ACT_BACKOFF;
            need_bo   = 1'b1;
        end

        if (go_fin)
        begin
            mode_next        = swarq_pkg::MODE_IDLE;
            act              = fin_act;
            res.report_id    = pid_reg;
            res.request_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= swarq_pkg::MODE_IDLE;
            att_reg   <= '0;
            bo_reg    <= '0;
            pdest_reg <= '0;
            pid_reg   <= '0;
        end
        else if (s_accept)
        begin
            mode_reg  <= mode_next;
            att_reg   <= att_next;
            bo_reg    <= bo_next;
            pdest_reg <= pdest_next;
            pid_reg   <= pid_next;
        end
    end

    // ---------------- backoff delay units ----------------
    swarq_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_w.random_draw),
        .exp       (bo_exp),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    swarq_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (mod_rem),
        .mcand   (slot_ms_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            swarq_pkg::SEQ_ACCEPT:
            begin
                if (s_accept)
                begin
                    seq_next = need_bo ? swarq_pkg::SEQ_MOD : swarq_pkg::SEQ_OUT;
                end
            end
            swarq_pkg::SEQ_MOD:
            begin
                if (mod_done)
                begin
                    seq_next = swarq_pkg::SEQ_MUL;
                end
            end
            swarq_pkg::SEQ_MUL:
            begin
                if (mul_done)
                begin
                    seq_next = swarq_pkg::SEQ_OUT;
                end
            end
            swarq_pkg::SEQ_OUT:
            begin
                if (out_free)
                begin
                    seq_next = swarq_pkg::SEQ_ACCEPT;
                end
            end
            default:
            begin
                seq_next = swarq_pkg::SEQ_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        mod_start = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (seq_reg)
            swarq_pkg::SEQ_ACCEPT:
            begin
                s_tready  = 1'b1;
                mod_start = s_tvalid && need_bo;
            end
            swarq_pkg::SEQ_MOD:
            begin
                mul_start = mod_done;
            end
            swarq_pkg::SEQ_MUL:
            begin
            end
            swarq_pkg::SEQ_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= swarq_pkg::SEQ_ACCEPT;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    // result stage
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            res_reg <= res;
            act_reg <= act;
        end
        else if ((seq_reg == swarq_pkg::SEQ_MUL) && mul_done)
        begin
            res_reg.timer_ms <= mul_prod;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_word_reg <= res_reg;
            m_act_reg  <= act_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_act_reg;
    assign m_tdata  = {{(swarq_pkg::OUT_BYTES*8 - swarq_pkg::OUT_W){1'b0}}, m_word_reg};

    // ---------------- checks ----------------
    `SWARQ_ASSERT_IMPLY(a_wait_ack_after_send, clk, rst_n,
        mode_reg == swarq_pkg::MODE_WAIT_ACK, att_reg != 5'd0)
    `SWARQ_ASSERT_NEXT(a_backoff_enters_mod, clk, rst_n,
        s_accept && need_bo, seq_reg == swarq_pkg::SEQ_MOD)
    `SWARQ_ASSERT_NEXT(a_mul_done_to_out, clk, rst_n,
        (seq_reg == swarq_pkg::SEQ_MUL) && mul_done, seq_reg == swarq_pkg::SEQ_OUT)
    `SWARQ_ASSERT_NEXT(a_load_shows_word, clk, rst_n, out_load, m_tvalid)

endmodule

// ===== rtl/core/swarq_mod.sv =====
`timescale 1ns / 1ps

// Bit-serial remainder: dividend mod (2^exp + 1), one dividend bit per cycle.
module swarq_mod
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [swarq_pkg::DRAW_W-1:0]    dividend,
    input  logic [3:0]                      exp,
    output logic                            done,
    output logic [swarq_pkg::DIV_W-1:0]     remainder
);

    localparam int CNT_W = $clog2(swarq_pkg::DIV_STEPS);

    logic                           busy_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [swarq_pkg::DRAW_W-1:0]   dvd_reg;
    logic [swarq_pkg::DIV_W-1:0]    div_reg;
    logic [swarq_pkg::DIV_W-1:0]    rem_reg;
    logic [swarq_pkg::DIV_W-1:0]    rem_next;
    logic [swarq_pkg::DIV_W:0]      trial;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[swarq_pkg::DRAW_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = swarq_pkg::DIV_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[swarq_pkg::DIV_W-1:0];
        end
    end

    assign done      = busy_reg && (cnt_reg == CNT_W'(swarq_pkg::DIV_STEPS - 1));
    assign remainder = rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= (swarq_pkg::DIV_W'(1) << exp) + swarq_pkg::DIV_W'(1);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[swarq_pkg::DRAW_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/core/swarq_mul.sv =====
`timescale 1ns / 1ps

// Shift-add multiplier: slots x slot length, one multiplier bit per cycle.
module swarq_mul
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [swarq_pkg::DIV_W-1:0]     mplier,
    input  logic [swarq_pkg::SLOT_W-1:0]    mcand,
    output logic                            done,
    output logic [swarq_pkg::TIMER_W-1:0]   product
);

    localparam int CNT_W = $clog2(swarq_pkg::MUL_STEPS);

    logic                           busy_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [swarq_pkg::DIV_W-1:0]    mpl_reg;
    logic [swarq_pkg::TIMER_W-1:0]  mcd_reg;
    logic [swarq_pkg::TIMER_W-1:0]  acc_reg;
    logic [swarq_pkg::TIMER_W-1:0]  acc_next;

    // product < 2^26, so the partial sums never wrap
    assign acc_next = mpl_reg[0] ? acc_reg + mcd_reg : acc_reg;
    assign done     = busy_reg && (cnt_reg == CNT_W'(swarq_pkg::MUL_STEPS - 1));
    assign product  = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mpl_reg <= mplier;
            mcd_reg <= swarq_pkg::TIMER_W'(mcand);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            mpl_reg <= {1'b0, mpl_reg[swarq_pkg::DIV_W-1:1]};
            mcd_reg <= {mcd_reg[swarq_pkg::TIMER_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import swarq_pkg::*;

    typedef struct {
        mode_t       mode;
        logic [4:0]  att;
        logic [7:0]  bo;
        logic [7:0]  dest;
        logic [15:0] id;
    } link_state_t;

    typedef struct {
        logic [7:0]  self_addr;
        logic [3:0]  max_retries;
        logic [3:0]  max_exp;
        logic [15:0] slot_ms;
        logic [4:0]  base_pwr;
        logic [2:0]  pwr_step;
        logic [15:0] ack_wait;
    } link_cfg_t;

    typedef struct {
        act_t      act;
        out_word_t res;
    } outcome_t;

    typedef struct {
        op_t      op;
        in_word_t w;
    } evt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [1:0]               s_tuser = '0;
    logic [IN_BYTES*8-1:0]    s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [2:0]               m_tuser;
    logic [OUT_BYTES*8-1:0]   m_tdata;
    logic                     cfg_we = 1'b0;
    logic [CFG_AW-1:0]        cfg_addr = '0;
    logic [CFG_W-1:0]         cfg_wdata = '0;

    stop_and_wait_arq_backoff_fsm_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // plan_* runs ahead at generation time to steer the stimulus,
    // live_* follows the words the block actually accepts
    link_state_t plan_st, live_st;
    link_cfg_t   plan_cfg, live_cfg;

    evt_t     pending_evts[$];
    outcome_t expected_results[$];

    int n_pushed   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errs     = 0;

    // next state and result of the link controller for one event
    function automatic void arq_next(inout link_state_t st, input link_cfg_t c,
                                     input op_t op, input in_word_t ev,
                                     output act_t act, output out_word_t res);
        bit     send;
        bit     backoff;
        int     e;
        int     slots;
        int     pwr;
        longint dly;
        send    = 1'b0;
        backoff = 1'b0;
        act     = ACT_NONE;
        res     = '0;
        case (st.mode)
            MODE_IDLE:
            begin
                if (op == OP_TX_REQ)
                begin
                    if (ev.queue_has_frame)
                    begin
                        res.pop_queue = 1'b1;
                        st.dest = ev.next_dest;
                        st.id   = ev.next_id;
                        st.att  = '0;
                        send    = ev.channel_idle;
                        backoff = !ev.channel_idle;
                    end
                    else
                    begin
                        act = ACT_LISTEN;
                    end
                end
            end
            MODE_WAIT_CHAN:
            begin
                if (op == OP_BACKOFF_TO)
                begin
                    send    = ev.channel_idle;
                    backoff = !ev.channel_idle;
                end
            end
            MODE_WAIT_ACK:
            begin
                if (op == OP_RX_FRAME)
                begin
                    if (ev.rx_is_ack && ev.rx_dest == c.self_addr &&
                        ev.rx_source == st.dest && ev.rx_id == st.id)
                    begin
                        res.stop_timer = 1'b1;
                        act = ACT_DELIVERED;
                    end
                end
                else if (op == OP_ACK_TO)
                begin
                    if (st.att > {1'b0, c.max_retries})
                    begin
                        act = ACT_FAILED;
                    end
                    else
                    begin
                        send    = ev.channel_idle;
                        backoff = !ev.channel_idle;
                    end
                end
            end
            default:
            begin
                st.mode = MODE_IDLE;
            end
        endcase

        if (act == ACT_DELIVERED || act == ACT_FAILED)
        begin
            st.mode = MODE_IDLE;
            res.report_id = st.id;
            res.request_next = 1'b1;
        end

        // radio refusal turns the send into a backoff
        if (send && !ev.send_ok)
        begin
            send    = 1'b0;
            backoff = 1'b1;
        end

        if (send)
        begin
            pwr = int'(c.base_pwr) + int'(st.att) * int'(c.pwr_step);
            res.retry_field = st.att;
            res.tx_power    = pwr[7:0];
            res.timer_ms    = {10'd0, c.ack_wait};
            st.bo = '0;
            if (st.att < ATT_SAT)
                st.att = st.att + 5'd1;
            st.mode = MODE_WAIT_ACK;
            act = ACT_TX;
        end

        if (backoff)
        begin
            e = int'(st.bo);
            if (e > int'(c.max_exp))
                e = int'(c.max_exp);
            if (e > int'(EXP_LIMIT))
                e = int'(EXP_LIMIT);
            if (st.bo < BO_SAT)
                st.bo = st.bo + 8'd1;
            slots = int'(ev.random_draw) % ((1 << e) + 1);
            dly = longint'(slots) * longint'(c.slot_ms);
            res.timer_ms = dly[25:0];
            st.mode = MODE_WAIT_CHAN;
            act = ACT_BACKOFF;
        end
    endfunction

    function automatic in_word_t rand_evt();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[IN_W-1:0];
    endfunction

    function automatic in_word_t tx_evt(bit has, bit [7:0] dest, bit [15:0] id,
                                        bit chan, bit sok, bit [15:0] draw);
        in_word_t w;
        w = rand_evt();
        w.queue_has_frame = has;
        w.next_dest       = dest;
        w.next_id         = id;
        w.channel_idle    = chan;
        w.send_ok         = sok;
        w.random_draw     = draw;
        return w;
    endfunction

    function automatic in_word_t rx_evt(bit [7:0] src, bit [7:0] dst, bit [15:0] id,
                                        bit ack);
        in_word_t w;
        w = rand_evt();
        w.rx_source = src;
        w.rx_dest   = dst;
        w.rx_id     = id;
        w.rx_is_ack = ack;
        return w;
    endfunction

    // queue one event; returns 1 if the block is planned to act on it
    function automatic bit push_evt(op_t op, in_word_t w);
        evt_t      it;
        act_t      a;
        out_word_t r;
        it.op = op;
        it.w  = w;
        pending_evts.push_back(it);
        n_pushed++;
        arq_next(plan_st, plan_cfg, op, w, a, r);
        return a != ACT_NONE;
    endfunction

    task automatic gen_random(int n_active, int busy_pct);
        int       got;
        op_t      op;
        in_word_t w;
        got = 0;
        while (got < n_active)
        begin
            w = rand_evt();
            w.channel_idle = ($urandom_range(99) >= busy_pct);
            w.send_ok      = ($urandom_range(99) < 85);
            if (busy_pct < 100 && $urandom_range(99) < 12)
            begin
                // noise: any opcode, any content
                w  = rand_evt();
                op = op_t'($urandom_range(3));
            end
            else
            begin
                case (plan_st.mode)
                    MODE_WAIT_CHAN:
                    begin
                        op = OP_BACKOFF_TO;
                    end
                    MODE_WAIT_ACK:
                    begin
                        if ($urandom_range(1) == 0)
                        begin
                            op = OP_ACK_TO;
                        end
                        else
                        begin
                            op = OP_RX_FRAME;
                            w.rx_is_ack = 1'b1;
                            w.rx_dest   = plan_cfg.self_addr;
                            w.rx_source = plan_st.dest;
                            w.rx_id     = plan_st.id;
                            if ($urandom_range(3) == 0)
                            begin
                                case ($urandom_range(3))
                                    0: w.rx_is_ack = 1'b0;
                                    1: w.rx_dest   ^= 8'(1 << $urandom_range(7));
                                    2: w.rx_source ^= 8'(1 << $urandom_range(7));
                                    default: w.rx_id ^= 16'(1 << $urandom_range(15));
                                endcase
                            end
                        end
                    end
                    default:
                    begin
                        op = OP_TX_REQ;
                        w.queue_has_frame = ($urandom_range(9) != 0);
                    end
                endcase
            end
            got += int'(push_evt(op, w));
        end
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    task automatic write_cfg(link_cfg_t c);
        put_reg(CFG_SELF_ADDR,   {8'd0, c.self_addr});
        put_reg(CFG_MAX_RETRIES, {12'd0, c.max_retries});
        put_reg(CFG_MAX_BO_EXP,  {12'd0, c.max_exp});
        put_reg(CFG_SLOT_MS,     c.slot_ms);
        put_reg(CFG_BASE_POWER,  {11'd0, c.base_pwr});
        put_reg(CFG_POWER_STEP,  {13'd0, c.pwr_step});
        put_reg(CFG_ACK_WAIT,    c.ack_wait);
        @(posedge clk);
        cfg_we <= 1'b0;
        plan_cfg = c;
        live_cfg = c;
    endtask

    // all results in, then room for a backoff still in the divider
    task automatic drain();
        while (n_results < n_pushed)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 n_results, what, got, want);
        n_errs++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    // sender: bursts of random length, random gaps between them
    act_t                  drv_act;
    out_word_t             drv_res;
    in_word_t              drv_in;
    logic [IN_BYTES*8-1:0] drv_word;
    evt_t                  cur;
    int                    burst_left = 0;
    int                    gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                drv_in = s_tdata[IN_W-1:0];
                arq_next(live_st, live_cfg, op_t'(s_tuser), drv_in, drv_act, drv_res);
                expected_results.push_back('{drv_act, drv_res});
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0 || pending_evts.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
                else
                begin
                    cur = pending_evts.pop_front();
                    drv_word = '0;
                    drv_word[IN_W-1:0] = cur.w;
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur.op;
                    s_tdata  <= drv_word;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(20, 1);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                    end
                end
            end
        end
    end

    // long receiver hold-off, once early on and now and then afterwards
    int hold_left = 0;
    bit held_once = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if ((!held_once && n_accepted >= 40) || $urandom_range(2999) == 0)
            begin
                hold_left <= $urandom_range(400, 200);
                held_once <= 1'b1;
            end
        end
    end

    // receiver stall pattern: rotating mask, reshuffled each time the 6-bit tick wraps
    logic [15:0] rx_pat = '1;
    logic [5:0]  rx_tick = '0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_tick = rx_tick + 6'd1;
            if (rx_tick == 6'd0)
                rx_pat = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
            else
                rx_pat = {rx_pat[14:0], rx_pat[15]};
            m_tready <= rx_pat[0] && hold_left == 0;
        end
    end

    outcome_t  mon_want;
    out_word_t mon_got;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report("result word with nothing expected", {29'd0, m_tuser}, '0);
            end
            else
            begin
                mon_want = expected_results.pop_front();
                mon_got  = m_tdata[OUT_W-1:0];
                check_field("action",       m_tuser,              mon_want.act);
                check_field("pop_queue",    mon_got.pop_queue,    mon_want.res.pop_queue);
                check_field("retry_field",  mon_got.retry_field,  mon_want.res.retry_field);
                check_field("tx_power",     mon_got.tx_power,     mon_want.res.tx_power);
                check_field("timer_ms",     mon_got.timer_ms,     mon_want.res.timer_ms);
                check_field("stop_timer",   mon_got.stop_timer,   mon_want.res.stop_timer);
                check_field("report_id",    mon_got.report_id,    mon_want.res.report_id);
                check_field("request_next", mon_got.request_next, mon_want.res.request_next);
            end
            n_results++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        link_cfg_t c;
        plan_st  = '{MODE_IDLE, 5'd0, 8'd0, 8'd0, 16'd0};
        live_st  = plan_st;
        plan_cfg = '{8'd1, 4'd3, 4'd5, 16'd100, 5'd2, 3'd1, 16'd500};
        live_cfg = plan_cfg;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk with reset registers (self 1, three retries)
        void'(push_evt(OP_RX_FRAME,   rx_evt(8'h00, 8'h01, 16'h0000, 1'b1)));
        void'(push_evt(OP_TX_REQ,     tx_evt(1'b0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        void'(push_evt(OP_TX_REQ,     tx_evt(1'b1, 8'hFF, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF)));
        void'(push_evt(OP_ACK_TO,     tx_evt(1'b1, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        void'(push_evt(OP_BACKOFF_TO, tx_evt(1'b1, 8'h00, 16'h0000, 1'b1, 1'b0, 16'hFFFF)));
        void'(push_evt(OP_BACKOFF_TO, tx_evt(1'b0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        // frames that are not a valid ACK for the pending frame
        void'(push_evt(OP_RX_FRAME,   rx_evt(8'hFF, 8'h00, 16'hFFFF, 1'b1)));
        void'(push_evt(OP_RX_FRAME,   rx_evt(8'hFE, 8'h01, 16'hFFFF, 1'b1)));
        void'(push_evt(OP_RX_FRAME,   rx_evt(8'hFF, 8'h01, 16'h7FFF, 1'b1)));
        void'(push_evt(OP_RX_FRAME,   rx_evt(8'hFF, 8'h01, 16'hFFFF, 1'b0)));
        void'(push_evt(OP_TX_REQ,     tx_evt(1'b1, 8'h12, 16'h3456, 1'b1, 1'b1, 16'h0)));
        // retries until the attempt budget runs out
        repeat (3)
            void'(push_evt(OP_ACK_TO, tx_evt(1'b0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        void'(push_evt(OP_ACK_TO,     tx_evt(1'b0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        void'(push_evt(OP_TX_REQ,     tx_evt(1'b1, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        void'(push_evt(OP_ACK_TO,     tx_evt(1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, 16'h8000)));
        void'(push_evt(OP_BACKOFF_TO, tx_evt(1'b0, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));
        void'(push_evt(OP_RX_FRAME,   rx_evt(8'h00, 8'h01, 16'h0000, 1'b1)));
        void'(push_evt(OP_BACKOFF_TO, tx_evt(1'b1, 8'h00, 16'h0000, 1'b1, 1'b1, 16'h0)));

        gen_random(120, 25);
        drain();

        write_cfg('{8'hFF, 4'd15, 4'd15, 16'hFFFF, 5'd31, 3'd7, 16'hFFFF});
        gen_random(120, 50);
        drain();

        write_cfg('{8'h00, 4'd0, 4'd0, 16'h0000, 5'd0, 3'd0, 16'h0000});
        gen_random(120, 25);
        drain();

        // channel never free: backoff counter saturates, exponent held at 10
        c.self_addr   = 8'($urandom);
        c.max_retries = 4'd15;
        c.max_exp     = 4'd15;
        c.slot_ms     = 16'hFFFF;
        c.base_pwr    = 5'($urandom);
        c.pwr_step    = 3'($urandom);
        c.ack_wait    = 16'($urandom);
        write_cfg(c);
        gen_random(280, 100);
        drain();

        c.self_addr   = 8'($urandom);
        c.max_retries = 4'($urandom_range(15));
        c.max_exp     = 4'($urandom_range(10));
        c.slot_ms     = 16'($urandom_range(300));
        c.base_pwr    = 5'($urandom);
        c.pwr_step    = 3'($urandom);
        c.ack_wait    = 16'($urandom);
        write_cfg(c);
        gen_random(110, 20);
        drain();

        if (expected_results.size() != 0)
            report("results never delivered", expected_results.size(), 0);
        if (n_errs == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/swarq_pkg.sv
rtl/core/swarq_mod.sv
rtl/core/swarq_mul.sv
rtl/core/stop_and_wait_arq_backoff_fsm_core.sv
tb/sv/tb.sv
